### hdl/utf16_to_code_point_decoder_defines.svh
// assertion macros shared by the decoder
`ifndef UTF16_TO_CODE_POINT_DECODER_DEFINES_SVH
`define UTF16_TO_CODE_POINT_DECODER_DEFINES_SVH

// same-cycle implication
`define U16D_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder check failed");

// next-cycle implication
`define U16D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder check failed");

`endif

### hdl/u16d_pkg.sv
package u16d_pkg;

  localparam int UnitW  = 16;
  localparam int PointW = 21;
  localparam int CountW = 16;
  localparam int OutDataW = 40;

  localparam logic [5:0] HighTag = 6'b110110;
  localparam logic [5:0] LowTag  = 6'b110111;
  localparam logic [PointW-1:0] SuppBase = 21'h10000;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;
  localparam logic [CountW-1:0] CapReset = 16'hFFFF;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             last_unit;
  } u16d_unit_t;

  typedef struct packed {
    logic [PointW-1:0] code_point;
    logic [CountW-1:0] char_count;
    logic              fits;
    logic              end_of_string;
    logic              status;
  } u16d_result_t;

  typedef struct packed {
    logic             high_pending;
    logic [UnitW-1:0] held_high;
  } u16d_hold_t;

endpackage

### hdl/u16d_in_reg.sv
module u16d_in_reg
  import u16d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  u16d_unit_t in_word_i,
  output logic       fwd_valid_o,
  input  logic       fwd_ready_i,
  output u16d_unit_t fwd_word_o
);

  logic       valid_d, valid_q;
  u16d_unit_t word_q;

  assign in_ready_o = !valid_q || fwd_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      word_q <= in_word_i;
    end
  end

  assign fwd_valid_o = valid_q;
  assign fwd_word_o  = word_q;

endmodule

### hdl/u16d_core.sv
module u16d_core
  import u16d_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  input  u16d_unit_t          item_i,
  input  logic [CountW-1:0]   capacity_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output u16d_result_t        res_o,
  output u16d_hold_t          hold_o
);

  logic              pending_d, pending_q;
  logic [UnitW-1:0]  held_d, held_q;
  logic [CountW-1:0] count_d, count_q;
  logic              is_high, is_low, pair, hold, produce, take, fit;
  logic [CountW-1:0] count_inc;

  assign is_high = (item_i.code_unit[15:10] == HighTag);
  assign is_low  = (item_i.code_unit[15:10] == LowTag);
  assign pair    = pending_q && is_low;
  assign hold    = !pair && !item_i.last_unit && is_high;
  assign produce = !hold;

  assign item_ready_o = !produce || res_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign res_valid_o  = item_valid_i && produce;

  assign fit       = count_q < capacity_i;
  assign count_inc = (count_q == CountMax) ? count_q : count_q + 16'd1;

  always_comb begin
    res_o.code_point    = pair
        ? {1'b0, held_q[9:0], item_i.code_unit[9:0]} + SuppBase
        : {5'd0, item_i.code_unit};
    res_o.char_count    = count_inc;
    res_o.fits          = fit;
    res_o.end_of_string = item_i.last_unit;
    res_o.status        = item_i.last_unit && !fit;
  end

  always_comb begin
    pending_d = pending_q;
    held_d    = held_q;
    count_d   = count_q;
    if (take) begin
      pending_d = hold;
      held_d    = hold ? item_i.code_unit : '0;
      if (produce) begin
        count_d = item_i.last_unit ? '0 : count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      held_q    <= '0;
      count_q   <= '0;
    end else begin
      pending_q <= pending_d;
      held_q    <= held_d;
      count_q   <= count_d;
    end
  end

  assign hold_o.high_pending = pending_q;
  assign hold_o.held_high    = held_q;

endmodule

### hdl/u16d_out_reg.sv
module u16d_out_reg
  import u16d_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         res_valid_i,
  output logic         res_ready_o,
  input  u16d_result_t res_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output u16d_result_t out_o
);

  logic         valid_d, valid_q;
  u16d_result_t res_q;

  assign res_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

### hdl/utf16_to_code_point_decoder.sv
// UTF-16 decoder: one code unit word per cycle goes in while tready is high, one code point
// word comes out for every unit that completes a character (a held high surrogate gives none).
// Sustained rate is one word per clock unless the sink stalls; words pass an input register,
// then an output register; the only stall comes from it, when the sink holds tready low. The
// capacity register (reset 65535) may be written only while no string is in flight.
`include "utf16_to_code_point_decoder_defines.svh"

module utf16_to_code_point_decoder
  import u16d_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CountW-1:0]   cfg_data_i,       // capacity
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [UnitW-1:0]    s_axis_tdata,     // code_unit
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,     // code_point, char_count, zero fill
  output logic                m_axis_tlast,
  output logic [1:0]          m_axis_tuser      // fits, status
);

  logic [CountW-1:0] capacity_q;
  u16d_unit_t        in_word, fwd_word;
  logic              fwd_valid, fwd_ready;
  u16d_result_t      res, out_res;
  logic              res_valid, res_ready;
  u16d_hold_t        hold;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapReset;
    end else if (cfg_valid_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  assign in_word.code_unit = s_axis_tdata;
  assign in_word.last_unit = s_axis_tlast;

  u16d_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_word_i   (in_word),
    .fwd_valid_o (fwd_valid),
    .fwd_ready_i (fwd_ready),
    .fwd_word_o  (fwd_word)
  );

  u16d_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (fwd_valid),
    .item_ready_o (fwd_ready),
    .item_i       (fwd_word),
    .capacity_i   (capacity_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .hold_o       (hold)
  );

  u16d_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_res)
  );

  assign m_axis_tdata = {3'd0, out_res.char_count, out_res.code_point};
  assign m_axis_tlast = out_res.end_of_string;
  assign m_axis_tuser = {out_res.status, out_res.fits};

  `U16D_ASSERT_IMP(a_status_on_end, clk_i, rst_ni,
                   m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && !m_axis_tuser[0])
  `U16D_ASSERT_IMP(a_count_nonzero, clk_i, rst_ni,
                   m_axis_tvalid, m_axis_tdata[36:21] != 16'd0)
  `U16D_ASSERT_IMP(a_held_is_high, clk_i, rst_ni,
                   hold.high_pending, hold.held_high[15:10] == HighTag)
  `U16D_ASSERT_NEXT(a_clear_after_last, clk_i, rst_ni,
                    fwd_valid && fwd_ready && fwd_word.last_unit, !hold.high_pending)

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import u16d_pkg::*;

  typedef struct packed {
    logic             wr_cap;
    logic [15:0]      cap;
    logic [UnitW-1:0] unit;
    logic             last;
    logic             typed;
    u16d_result_t     lit;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CountW-1:0]   cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [UnitW-1:0]    s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic [1:0]          m_axis_tuser;

  // decoder state as the bench sees it
  logic              hold_valid = 1'b0;
  logic [UnitW-1:0]  hold_unit = '0;
  logic [CountW-1:0] point_count = '0;
  logic [CountW-1:0] capacity_setting = CapReset;

  u16d_result_t expected_points[$];
  u16d_result_t want_point;
  int unsigned  error_count = 0;
  int unsigned  items_sent = 0;
  int           burst_left = 0;

  int          ready_span = 0;
  int          ready_mode = 0;
  logic [7:0]  ready_tick = '0;

  stim_row_t dir_rows [0:23] = '{
    '{1'b0, 16'h0, 16'h0000, 1'b1, 1'b1, '{21'h0, 16'd1, 1'b1, 1'b1, 1'b0}},
    '{1'b0, 16'h0, 16'hFFFF, 1'b1, 1'b1, '{21'hFFFF, 16'd1, 1'b1, 1'b1, 1'b0}},
    '{1'b0, 16'h0, 16'hD800, 1'b0, 1'b0, '0},
    '{1'b0, 16'h0, 16'hDC00, 1'b0, 1'b1, '{21'h10000, 16'd1, 1'b1, 1'b0, 1'b0}},
    '{1'b0, 16'h0, 16'hDBFF, 1'b0, 1'b0, '0},
    '{1'b0, 16'h0, 16'hDFFF, 1'b1, 1'b1, '{21'h10FFFF, 16'd2, 1'b1, 1'b1, 1'b0}},
    '{1'b0, 16'h0, 16'hDBFF, 1'b1, 1'b0, '0},
    '{1'b0, 16'h0, 16'hDC00, 1'b0, 1'b0, '0},
    '{1'b0, 16'h0, 16'hD800, 1'b0, 1'b0, '0},
    '{1'b0, 16'h0, 16'h0041, 1'b0, 1'b0, '0},
    '{1'b0, 16'h0, 16'hDA00, 1'b0, 1'b0, '0},
    '{1'b0, 16'h0, 16'hD9FF, 1'b0, 1'b0, '0},
    '{1'b0, 16'h0, 16'hDE00, 1'b0, 1'b0, '0},
    '{1'b0, 16'h0, 16'hD801, 1'b0, 1'b0, '0},
    '{1'b0, 16'h0, 16'hDFFF, 1'b1, 1'b0, '0},
    '{1'b0, 16'h0, 16'hD800, 1'b0, 1'b0, '0},
    '{1'b0, 16'h0, 16'hDBFF, 1'b1, 1'b0, '0},
    '{1'b0, 16'h0, 16'hDD00, 1'b1, 1'b0, '0},
    '{1'b0, 16'h0, 16'h5555, 1'b0, 1'b0, '0},
    '{1'b0, 16'h0, 16'hAAAA, 1'b1, 1'b0, '0},
    '{1'b1, 16'h0, 16'h0041, 1'b1, 1'b1, '{21'h41, 16'd1, 1'b0, 1'b1, 1'b1}},
    '{1'b1, 16'h1, 16'h0061, 1'b0, 1'b0, '0},
    '{1'b0, 16'h0, 16'h0062, 1'b1, 1'b1, '{21'h62, 16'd2, 1'b0, 1'b1, 1'b1}},
    '{1'b1, 16'hFFFF, 16'h1234, 1'b1, 1'b0, '0}
  };

  utf16_to_code_point_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit decode_unit(input logic [UnitW-1:0] unit, input logic last,
                                     output u16d_result_t point);
    logic [PointW-1:0] cp;
    logic              fit;
    point = '0;
    if (hold_valid && unit[15:10] == LowTag) begin
      cp = PointW'({hold_unit[9:0], unit[9:0]}) + SuppBase;
      hold_valid = 1'b0;
      hold_unit = '0;
    end else begin
      // a held high surrogate is dropped
      hold_valid = 1'b0;
      hold_unit = '0;
      if (!last && unit[15:10] == HighTag) begin
        hold_valid = 1'b1;
        hold_unit = unit;
        return 1'b0;
      end
      cp = PointW'(unit);
    end
    fit = point_count < capacity_setting;
    if (point_count != CountMax) point_count = point_count + 1'b1;
    point.code_point = cp;
    point.char_count = point_count;
    point.fits = fit;
    point.end_of_string = last;
    point.status = last && !fit;
    if (last) begin
      point_count = '0;
    end
    return 1'b1;
  endfunction

  function automatic logic [UnitW-1:0] plain_unit();
    logic [UnitW-1:0] u;
    u = UnitW'($urandom_range(0, 16'hFFFF));
    if (u[15:11] == 5'b11011) u[14] = ~u[14];
    return u;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic push_unit(input logic [UnitW-1:0] unit, input logic last,
                           input logic typed, input u16d_result_t lit);
    int           gap_len;
    u16d_result_t point;
    bit           has_point;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap_len > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= unit;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    has_point = decode_unit(unit, last, point);
    if (has_point) expected_points.push_back(typed ? lit : point);
  endtask

  task automatic drain_points();
    s_axis_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CountW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    capacity_setting = value;
  endtask

  // sink stalls in spans of varying style
  always @(posedge clk_i) begin
    if (ready_span == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_span <= $urandom_range(8, 80);
    end else begin
      ready_span <= ready_span - 1;
    end
    case (ready_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (ready_tick[2:0] != 3'd5);
    endcase
    ready_tick <= ready_tick + 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected word, code_point", m_axis_tdata[PointW-1:0], 0);
      end else begin
        want_point = expected_points.pop_front();
        if (m_axis_tdata[PointW-1:0] !== want_point.code_point)
          report_mismatch("code_point", m_axis_tdata[PointW-1:0], want_point.code_point);
        if (m_axis_tdata[PointW+CountW-1:PointW] !== want_point.char_count)
          report_mismatch("char_count", m_axis_tdata[PointW+CountW-1:PointW],
                          want_point.char_count);
        if (m_axis_tuser[0] !== want_point.fits)
          report_mismatch("fits", m_axis_tuser[0], want_point.fits);
        if (m_axis_tlast !== want_point.end_of_string)
          report_mismatch("end_of_string", m_axis_tlast, want_point.end_of_string);
        if (m_axis_tuser[1] !== want_point.status)
          report_mismatch("status", m_axis_tuser[1], want_point.status);
      end
    end
  end

  initial begin
    int               pieces;
    int               kind;
    logic             is_last;
    logic [UnitW-1:0] high_unit;
    logic [15:0]      cap_pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_cap) begin
        drain_points();
        write_capacity(dir_rows[i].cap);
      end
      push_unit(dir_rows[i].unit, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].lit);
    end

    while (items_sent < 1850) begin
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 5))
          0: cap_pick = 16'h0;
          1: cap_pick = 16'h1;
          2: cap_pick = 16'($urandom_range(2, 8));
          3: cap_pick = CapReset;
          4: cap_pick = 16'hFFFE;
          default: cap_pick = 16'($urandom_range(0, 16'hFFFF));
        endcase
        drain_points();
        write_capacity(cap_pick);
      end
      pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int p = 0; p < pieces; p++) begin
        is_last = (p == pieces - 1);
        kind = $urandom_range(0, 99);
        high_unit = 16'hD800 | 16'($urandom_range(0, 1023));
        if (kind < 50) begin
          push_unit(plain_unit(), is_last, 1'b0, '0);
        end else if (kind < 75) begin
          // well-formed surrogate pair
          push_unit(high_unit, 1'b0, 1'b0, '0);
          push_unit(16'hDC00 | 16'($urandom_range(0, 1023)), is_last, 1'b0, '0);
        end else if (kind < 83) begin
          push_unit(high_unit, is_last, 1'b0, '0);
        end else if (kind < 91) begin
          push_unit(16'hDC00 | 16'($urandom_range(0, 1023)), is_last, 1'b0, '0);
        end else begin
          push_unit(16'($urandom_range(0, 16'hFFFF)), is_last, 1'b0, '0);
        end
      end
    end

    drain_points();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/u16d_pkg.sv
hdl/u16d_in_reg.sv
hdl/u16d_core.sv
hdl/u16d_out_reg.sv
hdl/utf16_to_code_point_decoder.sv
bench/testbench.sv
